// ===== rtl/lvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Li-ion voltage to charge: shared package
// Widths, register indexes, item types and the fixed discharge curve tables.
// ----------------------------------------------------------------------------
package lvc_pkg;

    localparam int CURVE_POINTS    = 21;
    localparam int PT_W            = $clog2(CURVE_POINTS);
    localparam int MV_W            = 16;
    localparam int PCT_W           = 7;
    localparam int RATIO_W         = 16;
    localparam int RATIO_FRAC_BITS = 12;
    localparam int ROUND_W         = 2 * MV_W - RATIO_FRAC_BITS;
    // Widest segment span is 340 mV, so the offset into a segment fits in 9 bits.
    localparam int DIFF_W          = 9;
    // Rounded dividend 2*num + den stays below 2**X_W.
    localparam int X_W             = 17;
    localparam int RECIP_W         = 23;
    localparam int RECIP_SHIFT     = 27;
    localparam int QPROD_W         = X_W + RECIP_W;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RATIO = 2'd1;

    localparam logic [RATIO_W-1:0] DEFAULT_RATIO_RESET = 16'd8192;
    localparam logic [MV_W-1:0]    CELL_MV_MAX         = 16'hFFFF;
    localparam logic [PCT_W-1:0]   PCT_FULL            = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_EMPTY           = 7'd0;
    localparam logic [MV_W-1:0]    MV_TOP              = 16'd4200;
    localparam logic [MV_W-1:0]    MV_BOTTOM           = 16'd3270;

    typedef enum logic [1:0] {
        CLS_FULL,
        CLS_EMPTY,
        CLS_INTERP
    } t_cls;

    typedef struct packed {
        logic [MV_W-1:0] cell_mv;
        t_cls            cls;
        logic [PT_W-1:0] seg;
    } t_mid_item;

    typedef struct packed {
        logic [MV_W-1:0]  cell_mv;
        logic [PCT_W-1:0] pct;
    } t_out_item;

    // One segment, named by its lower point: base voltage and percent, percent
    // rise across it, its span in mV and ceil(2**RECIP_SHIFT / (2 * span)).
    typedef struct packed {
        logic [MV_W-1:0]    lo_mv;
        logic [PCT_W-1:0]   lo_pct;
        logic [PCT_W-1:0]   dp;
        logic [DIFF_W-1:0]  den;
        logic [RECIP_W-1:0] recip;
    } t_seg;

    function automatic logic [MV_W-1:0] curve_mv(input logic [PT_W-1:0] idx);
        logic [MV_W-1:0] mv;
        case (idx)
            5'd0:    mv = 16'd4200;
            5'd1:    mv = 16'd4150;
            5'd2:    mv = 16'd4110;
            5'd3:    mv = 16'd4080;
            5'd4:    mv = 16'd4020;
            5'd5:    mv = 16'd3980;
            5'd6:    mv = 16'd3950;
            5'd7:    mv = 16'd3910;
            5'd8:    mv = 16'd3870;
            5'd9:    mv = 16'd3850;
            5'd10:   mv = 16'd3840;
            5'd11:   mv = 16'd3820;
            5'd12:   mv = 16'd3800;
            5'd13:   mv = 16'd3790;
            5'd14:   mv = 16'd3770;
            5'd15:   mv = 16'd3750;
            5'd16:   mv = 16'd3730;
            5'd17:   mv = 16'd3710;
            5'd18:   mv = 16'd3690;
            5'd19:   mv = 16'd3610;
            5'd20:   mv = 16'd3270;
            default: mv = '0;
        endcase
        return mv;
    endfunction

    function automatic t_seg seg_info(input logic [PT_W-1:0] seg);
        t_seg s;
        case (seg)
            5'd1:    s = '{16'd4150, 7'd95, 7'd5, 9'd50,  23'd1342178};
            5'd2:    s = '{16'd4110, 7'd90, 7'd5, 9'd40,  23'd1677722};
            5'd3:    s = '{16'd4080, 7'd85, 7'd5, 9'd30,  23'd2236963};
            5'd4:    s = '{16'd4020, 7'd80, 7'd5, 9'd60,  23'd1118482};
            5'd5:    s = '{16'd3980, 7'd75, 7'd5, 9'd40,  23'd1677722};
            5'd6:    s = '{16'd3950, 7'd70, 7'd5, 9'd30,  23'd2236963};
            5'd7:    s = '{16'd3910, 7'd65, 7'd5, 9'd40,  23'd1677722};
            5'd8:    s = '{16'd3870, 7'd60, 7'd5, 9'd40,  23'd1677722};
            5'd9:    s = '{16'd3850, 7'd55, 7'd5, 9'd20,  23'd3355444};
            5'd10:   s = '{16'd3840, 7'd50, 7'd5, 9'd10,  23'd6710887};
            5'd11:   s = '{16'd3820, 7'd45, 7'd5, 9'd20,  23'd3355444};
            5'd12:   s = '{16'd3800, 7'd40, 7'd5, 9'd20,  23'd3355444};
            5'd13:   s = '{16'd3790, 7'd35, 7'd5, 9'd10,  23'd6710887};
            5'd14:   s = '{16'd3770, 7'd30, 7'd5, 9'd20,  23'd3355444};
            5'd15:   s = '{16'd3750, 7'd25, 7'd5, 9'd20,  23'd3355444};
            5'd16:   s = '{16'd3730, 7'd20, 7'd5, 9'd20,  23'd3355444};
            5'd17:   s = '{16'd3710, 7'd15, 7'd5, 9'd20,  23'd3355444};
            5'd18:   s = '{16'd3690, 7'd10, 7'd5, 9'd20,  23'd3355444};
            5'd19:   s = '{16'd3610, 7'd5,  7'd5, 9'd80,  23'd838861};
            5'd20:   s = '{16'd3270, 7'd0,  7'd5, 9'd340, 23'd197380};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lvc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Register queue
// Small first-in first-out queue of flip-flops with an occupancy count. The
// writer is trusted never to push into a full queue.
// ----------------------------------------------------------------------------
module lvc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_data,
    input  wire logic                         i_pop,
    output logic      [WIDTH-1:0]             o_data,
    output logic                              o_empty,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule
`default_nettype wire

// ===== rtl/lvc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end: accept, scale and classify
// Holds the ratio registers, scales each pin reading to a saturated cell
// voltage and finds the curve segment it falls in.
// ----------------------------------------------------------------------------
module lvc_front
    import lvc_pkg::*;
#(
    parameter int MID_DEPTH = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic signed [MV_W-1:0]          i_pin_millivolts,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic        [RATIO_W-1:0]       i_cfg_data,
    input  wire logic        [$clog2(MID_DEPTH+1)-1:0] i_mid_count,
    output logic                                 o_mid_push,
    output t_mid_item                            o_mid_data
);

    localparam int CNT_W  = $clog2(MID_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 2;
    localparam int PROD_W = (MV_W - 1) + RATIO_W;

    logic                  r_cfg_ready;
    logic [RATIO_W-1:0]    r_divider_ratio;
    logic [RATIO_W-1:0]    r_default_ratio;
    logic [RATIO_W-1:0]    w_ratio;
    logic                  w_accept;
    logic [SUM_W-1:0]      w_pending;

    logic                  r_f1_vld;
    logic                  r_f1_neg;
    logic [PROD_W-1:0]     r_f1_prod;
    logic                  r_f2_vld;
    logic [MV_W-1:0]       r_f2_mv;
    logic                  r_f3_vld;
    t_mid_item             r_f3_item;

    logic [ROUND_W-1:0]    w_round;
    logic [MV_W-1:0]       n_f2_mv;
    t_mid_item             n_f3_item;

    // Items already on their way to the queue count against its room.
    assign w_pending = SUM_W'(i_mid_count) + SUM_W'(r_f1_vld) + SUM_W'(r_f2_vld)
                     + SUM_W'(r_f3_vld);
    assign o_full    = (w_pending >= SUM_W'(MID_DEPTH));
    assign w_accept  = i_push && !o_full;

    assign w_ratio = (r_divider_ratio != '0) ? r_divider_ratio : r_default_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready     <= 1'b0;
            r_divider_ratio <= '0;
            r_default_ratio <= DEFAULT_RATIO_RESET;
        end else begin
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                case (i_cfg_index)
                    REG_DIVIDER_RATIO: r_divider_ratio <= i_cfg_data;
                    REG_DEFAULT_RATIO: r_default_ratio <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg_ready = r_cfg_ready;

    // Round half up, drop the fraction, saturate; a negative reading gives zero.
    always_comb begin
        w_round = ROUND_W'((32'(r_f1_prod) + 32'(1 << (RATIO_FRAC_BITS - 1)))
                           >> RATIO_FRAC_BITS);
        if (r_f1_neg) begin
            n_f2_mv = '0;
        end else if (w_round[ROUND_W-1:MV_W] != '0) begin
            n_f2_mv = CELL_MV_MAX;
        end else begin
            n_f2_mv = w_round[MV_W-1:0];
        end
    end

    // The segment is the first curve point, below the top one, that the
    // voltage reaches.
    always_comb begin
        n_f3_item.cell_mv = r_f2_mv;
        n_f3_item.seg     = PT_W'(1);
        for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
            if (r_f2_mv >= curve_mv(PT_W'(i))) begin
                n_f3_item.seg = PT_W'(i);
            end
        end
        if (r_f2_mv >= curve_mv('0)) begin
            n_f3_item.cls = CLS_FULL;
        end else if (r_f2_mv <= curve_mv(PT_W'(CURVE_POINTS - 1))) begin
            n_f3_item.cls = CLS_EMPTY;
        end else begin
            n_f3_item.cls = CLS_INTERP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
        end else begin
            r_f1_vld <= w_accept;
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_neg  <= i_pin_millivolts[MV_W-1];
        r_f1_prod <= PROD_W'(i_pin_millivolts[MV_W-2:0]) * PROD_W'(w_ratio);
        r_f2_mv   <= n_f2_mv;
        r_f3_item <= n_f3_item;
    end

    assign o_mid_push = r_f3_vld;
    assign o_mid_data = r_f3_item;

endmodule
`default_nettype wire

// ===== rtl/lvc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end: interpolation
// Takes classified items from the middle queue and works out the charge
// percent by linear interpolation with round half up, using a per-segment
// reciprocal in place of a divider.
// ----------------------------------------------------------------------------
module lvc_back
    import lvc_pkg::*;
#(
    parameter int OUT_DEPTH = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_mid_empty,
    input  wire t_mid_item                         i_mid_data,
    output logic                                   o_mid_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0]    i_out_count,
    output logic                                   o_out_push,
    output t_out_item                              o_out_data
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int SUM_W = CNT_W + 2;

    logic [SUM_W-1:0]   w_pending;
    t_seg               w_seg1;
    t_seg               w_seg2;
    t_seg               w_seg3;
    t_seg               w_seg_in;
    logic [MV_W-1:0]    w_diff_full;
    logic [PCT_W-1:0]   w_step;

    logic               r_b1_vld;
    t_mid_item          r_b1_item;
    logic [DIFF_W-1:0]  r_b1_diff;
    logic               r_b2_vld;
    t_mid_item          r_b2_item;
    logic [X_W-1:0]     r_b2_x;
    logic               r_b3_vld;
    t_mid_item          r_b3_item;
    logic [QPROD_W-1:0] r_b3_q;

    assign w_pending = SUM_W'(i_out_count) + SUM_W'(r_b1_vld) + SUM_W'(r_b2_vld)
                     + SUM_W'(r_b3_vld);
    assign o_mid_pop = !i_mid_empty && (w_pending < SUM_W'(OUT_DEPTH));

    assign w_seg_in    = seg_info(i_mid_data.seg);
    assign w_diff_full = i_mid_data.cell_mv - w_seg_in.lo_mv;
    assign w_seg1      = seg_info(r_b1_item.seg);
    assign w_seg2      = seg_info(r_b2_item.seg);
    assign w_seg3      = seg_info(r_b3_item.seg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
        end else begin
            r_b1_vld <= o_mid_pop;
            r_b2_vld <= r_b1_vld;
            r_b3_vld <= r_b2_vld;
        end
    end

    // (2*num + den) * recip >> RECIP_SHIFT equals (2*num + den) / (2*den)
    // exactly over the whole dividend range.
    always_ff @(posedge i_clk) begin
        r_b1_item <= i_mid_data;
        r_b1_diff <= w_diff_full[DIFF_W-1:0];
        r_b2_item <= r_b1_item;
        r_b2_x    <= X_W'({r_b1_diff, 1'b0}) * X_W'(w_seg1.dp) + X_W'(w_seg1.den);
        r_b3_item <= r_b2_item;
        r_b3_q    <= QPROD_W'(r_b2_x) * QPROD_W'(w_seg2.recip);
    end

    assign w_step = r_b3_q[RECIP_SHIFT +: PCT_W];

    always_comb begin
        o_out_data.cell_mv = r_b3_item.cell_mv;
        case (r_b3_item.cls)
            CLS_FULL:   o_out_data.pct = PCT_FULL;
            CLS_EMPTY:  o_out_data.pct = PCT_EMPTY;
            CLS_INTERP: o_out_data.pct = w_seg3.lo_pct + w_step;
            default:    o_out_data.pct = PCT_EMPTY;
        endcase
    end

    assign o_out_push = r_b3_vld;

endmodule
`default_nettype wire

// ===== rtl/liion_voltage_to_charge_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Li-ion voltage to charge estimator
// Scales an ADC pin reading to cell millivolts and maps it to a state of
// charge over a fixed 21-point discharge curve.
// ----------------------------------------------------------------------------
// Path: an item passes three front stages, the middle queue, three back
// stages and the output queue before its result is on the output ports.
// Throughput: one item per cycle while results are popped; the front and
// back pipelines each run at one item per cycle and the two queues absorb
// stalls on either side. Reset is synchronous and active low: both queues
// and pipelines empty, divider_ratio goes to 0, default_ratio to 8192 (2.0).
module liion_voltage_to_charge_core
    import lvc_pkg::*;
#(
    parameter int MID_DEPTH = 8,
    parameter int OUT_DEPTH = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire logic signed [MV_W-1:0]      i_pin_millivolts,
    output logic                             o_empty,
    input  wire logic                        i_pop,
    output logic             [MV_W-1:0]      o_cell_millivolts,
    output logic             [PCT_W-1:0]     o_charge_percent,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [RATIO_W-1:0]   i_cfg_data
);

    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int MID_W     = $bits(t_mid_item);
    localparam int OUT_W     = $bits(t_out_item);

    logic                 w_mid_push;
    t_mid_item            w_mid_wdata;
    logic [MID_W-1:0]     w_mid_rdata;
    logic                 w_mid_pop;
    logic                 w_mid_empty;
    logic [MID_CNT_W-1:0] w_mid_count;
    logic                 w_out_push;
    t_out_item            w_out_wdata;
    logic [OUT_W-1:0]     w_out_rdata;
    logic [OUT_CNT_W-1:0] w_out_count;
    t_out_item            w_out_head;

    lvc_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_pin_millivolts (i_pin_millivolts),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_mid_count      (w_mid_count),
        .o_mid_push       (w_mid_push),
        .o_mid_data       (w_mid_wdata)
    );

    lvc_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_wdata),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_rdata),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    lvc_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .i_mid_data  (t_mid_item'(w_mid_rdata)),
        .o_mid_pop   (w_mid_pop),
        .i_out_count (w_out_count),
        .o_out_push  (w_out_push),
        .o_out_data  (w_out_wdata)
    );

    lvc_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_wdata),
        .i_pop   (i_pop),
        .o_data  (w_out_rdata),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

    assign w_out_head        = t_out_item'(w_out_rdata);
    assign o_cell_millivolts = w_out_head.cell_mv;
    assign o_charge_percent  = w_out_head.pct;

endmodule
`default_nettype wire

// ===== rtl/lvc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for reset state, result range, the saturation
// ends of the curve and a waiting result holding steady until it is taken.
// ----------------------------------------------------------------------------
module lvc_checker
    import lvc_pkg::*;
(
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_full,
    input wire logic                        o_empty,
    input wire logic                        i_pop,
    input wire logic        [MV_W-1:0]      o_cell_millivolts,
    input wire logic        [PCT_W-1:0]     o_charge_percent
);

    // Reset leaves no result waiting and room for a new item.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not cleared by reset");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_charge_percent <= PCT_FULL))
        else $error("charge percent above 100");

    a_top_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_cell_millivolts >= MV_TOP)) |-> (o_charge_percent == PCT_FULL))
        else $error("voltage at top of curve without full charge");

    a_bottom_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_cell_millivolts <= MV_BOTTOM)) |-> (o_charge_percent == PCT_EMPTY))
        else $error("voltage at bottom of curve with nonzero charge");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=>
            (!o_empty && $stable(o_cell_millivolts) && $stable(o_charge_percent)))
        else $error("waiting result changed before it was taken");

endmodule

bind liion_voltage_to_charge_core lvc_checker u_lvc_checker (.*);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Li-ion voltage to charge: self-checking testbench
// Drives pin readings into the block under several divider ratio
// settings and idle patterns, predicts cell millivolts and state of charge
// for every accepted item, and checks each popped result in order.
// ----------------------------------------------------------------------------
module testbench;
    import lvc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int                   PHASES      = 10;
    localparam int                   PHASE_ITEMS = 165;

    // Tracks the register settings, predicts each reading's result and holds
    // the results still owed by the block, oldest first.
    class charge_ledger;
        logic [RATIO_W-1:0] divider_ratio;
        logic [RATIO_W-1:0] default_ratio;
        int unsigned        knee_mv[21];
        int unsigned        knee_pct[21];
        t_out_item          owed[$];
        int                 failures;

        function new();
            divider_ratio = '0;
            default_ratio = 16'd8192;
            failures      = 0;
            knee_mv  = '{4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910, 3870, 3850, 3840,
                         3820, 3800, 3790, 3770, 3750, 3730, 3710, 3690, 3610, 3270};
            knee_pct = '{100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
                         45, 40, 35, 30, 25, 20, 15, 10, 5, 0};
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [RATIO_W-1:0] val);
            case (idx)
                REG_DIVIDER_RATIO: divider_ratio = val;
                REG_DEFAULT_RATIO: default_ratio = val;
                default: ;
            endcase
        endfunction

        function logic [RATIO_W-1:0] effective_ratio();
            return (divider_ratio != '0) ? divider_ratio : default_ratio;
        endfunction

        function logic [MV_W-1:0] scale_to_cell(input logic signed [MV_W-1:0] pin);
            logic [47:0] prod;
            if (pin[MV_W-1])
                return '0;
            prod = {32'd0, pin};
            prod = prod * {32'd0, effective_ratio()};
            prod = (prod + 48'd2048) >> RATIO_FRAC_BITS;
            if (prod > 48'd65535)
                return CELL_MV_MAX;
            return prod[MV_W-1:0];
        endfunction

        // Linear interpolation between neighbouring knees, rounded half up.
        function logic [PCT_W-1:0] estimate_charge(input logic [MV_W-1:0] mv);
            int unsigned m;
            int unsigned den;
            int unsigned num;
            m = mv;
            if (m >= knee_mv[0])
                return PCT_FULL;
            if (m <= knee_mv[20])
                return PCT_EMPTY;
            for (int i = 1; i < 21; i++) begin
                if (m >= knee_mv[i]) begin
                    den = knee_mv[i-1] - knee_mv[i];
                    num = (m - knee_mv[i]) * (knee_pct[i-1] - knee_pct[i]);
                    return PCT_W'(knee_pct[i] + (2 * num + den) / (2 * den));
                end
            end
            return PCT_EMPTY;
        endfunction

        function void note_reading(input logic signed [MV_W-1:0] pin);
            t_out_item exp_item;
            exp_item.cell_mv = scale_to_cell(pin);
            exp_item.pct     = estimate_charge(exp_item.cell_mv);
            owed.push_back(exp_item);
        endfunction

        function void check_result(input logic [MV_W-1:0] cell_mv,
                                   input logic [PCT_W-1:0] pct);
            t_out_item exp_item;
            if (owed.size() == 0) begin
                $error("result with nothing owed: cell_millivolts %0d charge_percent %0d",
                       cell_mv, pct);
                failures++;
                return;
            end
            exp_item = owed.pop_front();
            if (cell_mv !== exp_item.cell_mv) begin
                $error("cell_millivolts: expected %0d, got %0d", exp_item.cell_mv, cell_mv);
                failures++;
            end
            if (pct !== exp_item.pct) begin
                $error("charge_percent: expected %0d, got %0d", exp_item.pct, pct);
                failures++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_push = 1'b0;
    logic signed [MV_W-1:0]      i_pin_millivolts = '0;
    logic                        i_pop = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic        [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic        [RATIO_W-1:0]   i_cfg_data = '0;
    logic                        o_full;
    logic                        o_empty;
    logic        [MV_W-1:0]      o_cell_millivolts;
    logic        [PCT_W-1:0]     o_charge_percent;
    logic                        o_cfg_ready;

    charge_ledger ledger = new();
    int           send_idle_pct = 0;
    int           pop_stall_pct = 0;

    logic signed [MV_W-1:0] directed_pins[12] = '{
        16'sd0, 16'sd1, -16'sd1, 16'sh8000, 16'sh7FFF, 16'sd2100,
        16'sd2101, 16'sd1635, 16'sd1636, 16'sd1911, 16'sd1720, 16'sd1805
    };

    liion_voltage_to_charge_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_pin_millivolts  (i_pin_millivolts),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_cell_millivolts (o_cell_millivolts),
        .o_charge_percent  (o_charge_percent),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("tb: failure");
        $finish;
    end

    // Result side: values seen here are those from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty)
            ledger.check_result(o_cell_millivolts, o_charge_percent);
        i_pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 55; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 55; end
            default: begin send_idle_pct = 33; pop_stall_pct = 33; end
        endcase
    endtask

    task automatic send_reading(input logic signed [MV_W-1:0] pin);
        if ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_push           <= 1'b1;
        i_pin_millivolts <= pin;
        do @(posedge i_clk); while (o_full);
        ledger.note_reading(pin);
    endtask

    // Stops pushing and waits for every owed result.
    task automatic drain_results();
        i_push <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly readings aimed at the curve for the current ratio, with some
    // negative, extreme and fully random ones.
    function automatic logic signed [MV_W-1:0] random_reading();
        int unsigned pick;
        int unsigned target;
        int unsigned ratio;
        int unsigned pin;
        pick = $urandom_range(99);
        if (pick < 12)
            return MV_W'($urandom);
        if (pick < 22)
            return {1'b1, 15'($urandom)};
        if (pick < 28) begin
            case ($urandom_range(3))
                0: return 16'sh0000;
                1: return 16'sh7FFF;
                2: return 16'sh0001;
                default: return 16'sh8000;
            endcase
        end
        ratio  = ledger.effective_ratio();
        target = $urandom_range(3200, 4300);
        if (ratio == 0)
            return MV_W'($urandom_range(0, 32767));
        pin = (target * 4096 + ratio / 2) / ratio;
        if (pin > 32767)
            pin = $urandom_range(0, 32767);
        return MV_W'(pin);
    endfunction

    initial begin
        logic [RATIO_W-1:0] divider;
        logic [RATIO_W-1:0] fallback;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset ratio of 2.0 gives exact even cell voltages.
        set_idling(0);
        foreach (directed_pins[k])
            send_reading(directed_pins[k]);
        drain_results();
        write_reg(REG_DIVIDER_RATIO, 16'd4096);
        send_reading(16'sd3841);
        send_reading(16'sd4199);
        send_reading(16'sd3271);
        send_reading(16'sd4200);
        drain_results();
        write_reg(REG_DIVIDER_RATIO, 16'hFFFF);
        send_reading(16'sh7FFF);
        send_reading(16'sd4096);
        send_reading(16'sd4095);
        drain_results();
        write_reg(REG_DIVIDER_RATIO, 16'd0);
        write_reg(REG_DEFAULT_RATIO, 16'd0);
        send_reading(16'sd1000);
        send_reading(16'sh7FFF);
        drain_results();
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h5A5A);
        write_reg(REG_DIVIDER_RATIO, 16'd1);
        send_reading(16'sh7FFF);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin divider = 16'd0;     fallback = 16'd8192;   end
                1: begin divider = 16'd4096;  fallback = 16'($urandom_range(1, 65535)); end
                2: begin divider = 16'($urandom_range(1, 65535)); fallback = 16'd8192; end
                3: begin divider = 16'hFFFF;  fallback = 16'd1;      end
                4: begin divider = 16'd0;     fallback = 16'd1;      end
                5: begin divider = 16'd0;     fallback = 16'hFFFF;   end
                6: begin divider = 16'd1;     fallback = 16'($urandom); end
                7: begin divider = 16'($urandom); fallback = 16'($urandom); end
                8: begin divider = 16'd0;     fallback = 16'd0;      end
                default: begin
                    divider  = 16'($urandom_range(3000, 9000));
                    fallback = 16'($urandom_range(3000, 9000));
                end
            endcase
            write_reg(REG_DIVIDER_RATIO, divider);
            write_reg(REG_DEFAULT_RATIO, fallback);
            write_reg((p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
            set_idling(p);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Once mid-run the sender holds off until the block has emptied.
                if (p == 4 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_reading(random_reading());
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
